### hw/rtl/rrlsq_pkg.sv
// Shared types and constants for the retry rate limited send queue.
`timescale 1ns / 1ps
`default_nettype none
package rrlsq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_HANDLE_BITS = 16;

  localparam int HANDLE_W  = 16;
  localparam int TIME_W    = 32;
  localparam int GAP_W     = 16;
  localparam int MDEPTH_W  = 5;
  localparam int RETRY_W   = 8;
  localparam int OUTCNT_W  = 5;
  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 64;
  localparam int ADDR_W    = 5;
  localparam int APB_W     = 32;

  localparam logic [GAP_W-1:0]    GAP_FLOOR       = 16'd10;
  localparam logic [GAP_W-1:0]    RST_MIN_GAP     = 16'd100;
  localparam logic [MDEPTH_W-1:0] RST_MAX_DEPTH   = 5'd10;
  localparam logic [RETRY_W-1:0]  RST_MAX_RETRIES = 8'd10;
  localparam logic [RETRY_W-1:0]  ATTEMPT_MAX     = 8'hFF;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_FETCH = 2'd1,
    ACT_MARK  = 2'd2,
    ACT_DELAY = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    REG_MIN_GAP     = 3'd0,
    REG_MAX_DEPTH   = 3'd1,
    REG_MAX_RETRIES = 3'd2,
    REG_DEL_OLDEST  = 3'd3,
    REG_EXPIRE      = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EXP_WAIT,
    ST_EXP_CHECK,
    ST_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [GAP_W-1:0]    min_gap_ms;
    logic [MDEPTH_W-1:0] max_depth;
    logic [RETRY_W-1:0]  retry_limit;
    logic                evict_old;
    logic [TIME_W-1:0]   expire_ms;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic pop;
    logic drop;
    logic stamp_send;
    logic push;
    logic attempt_inc;
    logic delay_set;
    logic calc_t;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic empty;
    logic full;
    logic retry_over;
    logic expire_en;
    logic expired;
    logic success;
    logic evict_old;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

### hw/rtl/rrlsq_regs.sv
// APB configuration registers.
`timescale 1ns / 1ps
`default_nettype none
module rrlsq_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rrlsq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rrlsq_pkg::APB_W-1:0]  pwdata,
  output logic      [rrlsq_pkg::APB_W-1:0]  prdata,
  output logic                              pready,
  output rrlsq_pkg::cfg_t                   cfg
);
  import rrlsq_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_gap_ms  <= RST_MIN_GAP;
      cfg.max_depth   <= RST_MAX_DEPTH;
      cfg.retry_limit <= RST_MAX_RETRIES;
      cfg.evict_old   <= 1'b0;
      cfg.expire_ms   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_MIN_GAP:     cfg.min_gap_ms  <= pwdata[GAP_W-1:0];
        REG_MAX_DEPTH:   cfg.max_depth   <= pwdata[MDEPTH_W-1:0];
        REG_MAX_RETRIES: cfg.retry_limit <= pwdata[RETRY_W-1:0];
        REG_DEL_OLDEST:  cfg.evict_old   <= pwdata[0];
        REG_EXPIRE:      cfg.expire_ms   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_GAP:     prdata = APB_W'(cfg.min_gap_ms);
      REG_MAX_DEPTH:   prdata = APB_W'(cfg.max_depth);
      REG_MAX_RETRIES: prdata = APB_W'(cfg.retry_limit);
      REG_DEL_OLDEST:  prdata = APB_W'(cfg.evict_old);
      REG_EXPIRE:      prdata = APB_W'(cfg.expire_ms);
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/rrlsq_ctrl.sv
// Controller state machine sequencing one transaction at a time.
`timescale 1ns / 1ps
`default_nettype none
module rrlsq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rrlsq_pkg::sts_t sts,
  output rrlsq_pkg::cmd_t      cmd
);
  import rrlsq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.act)
          ACT_PUSH: begin
            if (sts.evict_old && sts.full) begin
              cmd.pop  = 1'b1;
              cmd.drop = 1'b1;
            end else begin
              cmd.push   = !sts.full;
              state_next = ST_WAIT;
            end
          end
          ACT_FETCH: begin
            if (!sts.empty && sts.retry_over) begin
              cmd.pop  = 1'b1;
              cmd.drop = 1'b1;
            end
            state_next = ST_EXP_WAIT;
          end
          ACT_MARK: begin
            if (!sts.empty) begin
              if (sts.success) begin
                cmd.pop        = 1'b1;
                cmd.stamp_send = 1'b1;
              end else begin
                cmd.attempt_inc = 1'b1;
              end
            end
            state_next = ST_WAIT;
          end
          ACT_DELAY: begin
            cmd.delay_set = 1'b1;
            state_next    = ST_WAIT;
          end
          default: state_next = ST_WAIT;
        endcase
      end
      ST_EXP_WAIT: state_next = ST_EXP_CHECK;
      ST_EXP_CHECK: begin
        if (sts.expire_en && !sts.empty && sts.expired) begin
          cmd.pop    = 1'b1;
          cmd.drop   = 1'b1;
          state_next = ST_EXP_WAIT;
        end else begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cmd.calc_t = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/rrlsq_datapath.sv
// Datapath: entry stores, queue pointers, send timing and output register.
`timescale 1ns / 1ps
`default_nettype none
module rrlsq_datapath #(
  parameter int QUEUE_DEPTH = rrlsq_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = rrlsq_pkg::DEF_HANDLE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rrlsq_pkg::cfg_t                  cfg,
  input  wire rrlsq_pkg::cmd_t                  cmd,
  output rrlsq_pkg::sts_t                       sts,
  input  wire logic [1:0]                       in_act,
  input  wire logic [rrlsq_pkg::HANDLE_W-1:0]   in_handle,
  input  wire logic [rrlsq_pkg::TIME_W-1:0]     in_now,
  input  wire logic                             in_success,
  input  wire logic [rrlsq_pkg::TIME_W-1:0]     in_delay,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [rrlsq_pkg::OUT_DATA_W-1:0] out_data
);
  import rrlsq_pkg::*;

  localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

  logic [STORE_W-1:0] handle_mem [QUEUE_DEPTH];
  logic [TIME_W-1:0]  time_mem   [QUEUE_DEPTH];
  logic [STORE_W-1:0] rd_handle;
  logic [TIME_W-1:0]  rd_time;

  act_t               act;
  logic [STORE_W-1:0] handle;
  logic [TIME_W-1:0]  now;
  logic               success;
  logic [TIME_W-1:0]  delay;

  logic [PTR_W-1:0]   head_ptr;
  logic [PTR_W-1:0]   tail_ptr;
  logic [CNT_W-1:0]   count;
  logic [RETRY_W-1:0] attempt;
  logic [TIME_W-1:0]  last_send;
  logic [CNT_W-1:0]   drop_cnt;
  logic               push_ok;
  logic [TIME_W-1:0]  t_base;

  logic [CNT_W-1:0]   depth_eff;
  logic [GAP_W-1:0]   gap;
  logic [TIME_W-1:0]  age;
  logic [TIME_W-1:0]  diff;
  logic [TIME_W-1:0]  t_sel;
  logic [TIME_W-1:0]  next_time;
  logic               empty;
  logic               ok_bit;
  logic               hv_bit;
  logic [HANDLE_W-1:0] hh;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    if (cfg.max_depth == '0)
      depth_eff = CNT_W'(1);
    else if (32'(cfg.max_depth) > 32'(QUEUE_DEPTH))
      depth_eff = CNT_W'(QUEUE_DEPTH);
    else
      depth_eff = CNT_W'(cfg.max_depth);
  end

  assign empty = (count == '0);
  assign gap   = (cfg.min_gap_ms < GAP_FLOOR) ? GAP_FLOOR : cfg.min_gap_ms;
  assign age   = now - rd_time;

  assign sts.act        = act;
  assign sts.empty      = empty;
  assign sts.full       = (count >= depth_eff);
  assign sts.retry_over = (attempt > cfg.retry_limit);
  assign sts.expire_en  = (cfg.expire_ms != '0);
  assign sts.expired    = (age >= cfg.expire_ms);
  assign sts.success    = success;
  assign sts.evict_old  = cfg.evict_old;
  assign sts.out_busy   = out_valid && !out_ready;

  // entry stores: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.push) handle_mem[tail_ptr] <= handle;
    rd_handle <= handle_mem[head_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) time_mem[tail_ptr] <= now;
    rd_time <= time_mem[head_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act     <= act_t'(in_act);
      handle  <= in_handle[STORE_W-1:0];
      now     <= in_now;
      success <= in_success;
      delay   <= in_delay;
    end
    if (cmd.calc_t) t_base <= last_send + TIME_W'(gap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr  <= '0;
      tail_ptr  <= '0;
      count     <= '0;
      attempt   <= '0;
      last_send <= '0;
      drop_cnt  <= '0;
      push_ok   <= 1'b0;
    end else begin
      if (cmd.capture) begin
        drop_cnt <= '0;
        push_ok  <= 1'b0;
      end
      if (cmd.pop) begin
        head_ptr <= ptr_inc(head_ptr);
        count    <= count - 1'b1;
        attempt  <= '0;
      end else if (cmd.push) begin
        tail_ptr <= ptr_inc(tail_ptr);
        count    <= count + 1'b1;
        push_ok  <= 1'b1;
      end else if (cmd.attempt_inc && attempt != ATTEMPT_MAX) begin
        attempt <= attempt + 1'b1;
      end
      if (cmd.drop)       drop_cnt  <= drop_cnt + 1'b1;
      if (cmd.stamp_send) last_send <= now;
      if (cmd.delay_set)  last_send <= now + delay;
    end
  end

  always_comb begin
    diff      = now - t_base;
    t_sel     = (diff != '0 && !diff[TIME_W-1]) ? now : t_base;
    if (empty)            next_time = '0;
    else if (t_sel == '0) next_time = TIME_W'(1);
    else                  next_time = t_sel;
    ok_bit = (act == ACT_PUSH) ? push_ok : !empty;
    hv_bit = (act == ACT_FETCH) && !empty;
    hh     = empty ? '0 : HANDLE_W'(rd_handle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= OUT_DATA_W'({next_time, OUTCNT_W'(count), OUTCNT_W'(drop_cnt),
                               hh, hv_bit, ok_bit});
    end
  end

endmodule
`default_nettype wire

### hw/rtl/retry_rate_limited_send_queue.sv
// Top level of the retry rate limited send queue.
// A bounded queue of message handles stamped with their push time. Each input
// transaction carries an action (push, fetch head, mark processed, add delay) and
// yields exactly one result transaction with the push/non-empty flag, head
// handle, count of entries dropped, entries left and the next schedule time.
// One transaction is worked at a time; the next is accepted as soon as the
// previous result sits in the output register. A push drops entries one at a
// time to make room when eviction is on; a fetch drops an over-retried head,
// then each entry aged out, waiting on the head read after each drop. This
// order is set by the single registered read port of the entry stores, which
// must settle after each head change. The stores need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none
module retry_rate_limited_send_queue #(
  parameter int QUEUE_DEPTH = rrlsq_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = rrlsq_pkg::DEF_HANDLE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // handle[15:0], now_ms[47:16], success[48], delay_ms[80:49], zero fill
  input  wire logic [rrlsq_pkg::IN_DATA_W-1:0]  s_tdata,
  // action[1:0]
  input  wire logic [1:0]                       s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // ok[0], head_valid[1], head_handle[17:2], dropped[22:18],
  // queue_count[27:23], next_time_ms[59:28], zero fill
  output logic      [rrlsq_pkg::OUT_DATA_W-1:0] m_tdata,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rrlsq_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [rrlsq_pkg::APB_W-1:0]      pwdata,
  output logic      [rrlsq_pkg::APB_W-1:0]      prdata,
  output logic                                  pready
);
  import rrlsq_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rrlsq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rrlsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrlsq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_act     (s_tuser),
    .in_handle  (s_tdata[15:0]),
    .in_now     (s_tdata[47:16]),
    .in_success (s_tdata[48]),
    .in_delay   (s_tdata[80:49]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata)
  );

endmodule
`default_nettype wire
